FILE: sv/dfrp_pkg.sv
package dfrp_pkg;

  // buffer limits for a frame, in bytes
  localparam int unsigned CMD_BUFFER_BYTES   = 64;
  localparam int unsigned EVENT_BUFFER_BYTES = 16;

  // frame bytes kept for decoding (bytes 0..5 are the only ones read)
  localparam int unsigned HEAD_DEPTH = 6;
  localparam int unsigned HEAD_AW    = $clog2(HEAD_DEPTH);

  // entries of the queue between parser and formatter
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] END_BYTE = 8'hFF;

  // start codes
  localparam logic [7:0] SC_FAIL      = 8'h00;
  localparam logic [7:0] SC_OK        = 8'h01;
  localparam logic [7:0] SC_ID_A      = 8'h02;
  localparam logic [7:0] SC_ID_B      = 8'h03;
  localparam logic [7:0] SC_ID_C      = 8'h04;
  localparam logic [7:0] SC_ID_D      = 8'h05;
  localparam logic [7:0] SC_WRONG_VAR = 8'h1A;
  localparam logic [7:0] SC_DEV_OVFL  = 8'h24;
  localparam logic [7:0] SC_TOUCH     = 8'h65;
  localparam logic [7:0] SC_SENDME    = 8'h66;
  localparam logic [7:0] SC_XY_PRESS  = 8'h67;
  localparam logic [7:0] SC_XY_WAKE   = 8'h68;
  localparam logic [7:0] SC_STRING    = 8'h70;
  localparam logic [7:0] SC_NUMBER    = 8'h71;
  localparam logic [7:0] SC_SLEEP     = 8'h86;
  localparam logic [7:0] SC_WAKE      = 8'h87;
  localparam logic [7:0] SC_READY     = 8'h88;
  localparam logic [7:0] SC_TD_END    = 8'hFD;
  localparam logic [7:0] SC_TD_READY  = 8'hFE;

  // minimum end index per start code
  localparam logic [3:0] LEN_DEFAULT = 4'd3;
  localparam logic [3:0] LEN_SHORT   = 4'd4;
  localparam logic [3:0] LEN_START   = 4'd5;
  localparam logic [3:0] LEN_TOUCH   = 4'd6;
  localparam logic [3:0] LEN_NUMBER  = 4'd7;
  localparam logic [3:0] LEN_XY      = 4'd8;

  typedef enum logic [4:0] {
    ST_INCOMPLETE = 5'd0,
    ST_OK         = 5'd1,
    ST_FAIL       = 5'd2,
    ST_STARTUP    = 5'd3,
    ST_READY      = 5'd4,
    ST_WRONG_ID   = 5'd5,
    ST_WRONG_VAR  = 5'd6,
    ST_DEV_OVFL   = 5'd7,
    ST_TOUCH      = 5'd8,
    ST_SLEEP      = 5'd9,
    ST_STRING     = 5'd10,
    ST_NUMBER     = 5'd11,
    ST_SENDME     = 5'd12,
    ST_TD_END     = 5'd13,
    ST_TD_READY   = 5'd14,
    ST_UNKNOWN    = 5'd15,
    ST_BUF_OVFL   = 5'd16,
    ST_NOT_INIT   = 5'd17
  } status_e;

  // one classified word handed from parser to formatter
  typedef struct packed {
    status_e    status;
    logic [7:0] code;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] str_len;
  } rec_t;

endpackage

FILE: sv/dfrp_front.sv
module dfrp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              enabled_i,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              fresh_read_i,
  input  logic              event_limit_i,
  output dfrp_pkg::rec_t    rec_o
);
  import dfrp_pkg::*;

  logic [7:0] byte_index_q, byte_index_d;
  logic [3:0] exp_len_q, exp_len_d;
  logic [7:0] prev0_q, prev0_d;
  logic [7:0] prev1_q, prev1_d;
  logic [7:0] head_q [HEAD_DEPTH];

  logic [7:0] idx;
  logic [3:0] exp_cur;
  logic [7:0] p0, p1;
  logic [7:0] code;
  logic       is_end;
  logic [8:0] cnt_inc;
  logic [8:0] limit;
  status_e    st;

  function automatic logic [3:0] min_length(input logic [7:0] c);
    case (c)
      SC_TOUCH:                min_length = LEN_TOUCH;
      SC_XY_PRESS, SC_XY_WAKE: min_length = LEN_XY;
      SC_SENDME, SC_STRING:    min_length = LEN_SHORT;
      SC_NUMBER:               min_length = LEN_NUMBER;
      default:                 min_length = LEN_DEFAULT;
    endcase
  endfunction

  function automatic status_e classify(input logic [7:0] c, input logic [7:0] n,
                                       input logic [7:0] h1, input logic [7:0] h2);
    logic n3;
    n3 = (n == {4'd0, LEN_DEFAULT});
    case (c)
      SC_FAIL: begin
        if (n3) classify = ST_FAIL;
        else if (n == {4'd0, LEN_START} && h1 == 8'd0 && h2 == 8'd0) classify = ST_STARTUP;
        else classify = ST_UNKNOWN;
      end
      SC_OK:                            classify = n3 ? ST_OK : ST_UNKNOWN;
      SC_READY:                         classify = n3 ? ST_READY : ST_UNKNOWN;
      SC_ID_A, SC_ID_B, SC_ID_C, SC_ID_D: classify = n3 ? ST_WRONG_ID : ST_UNKNOWN;
      SC_WRONG_VAR:                     classify = n3 ? ST_WRONG_VAR : ST_UNKNOWN;
      SC_DEV_OVFL:                      classify = n3 ? ST_DEV_OVFL : ST_UNKNOWN;
      SC_TOUCH: classify = (n == {4'd0, LEN_TOUCH}) ? ST_TOUCH : ST_UNKNOWN;
      SC_XY_PRESS, SC_XY_WAKE: classify = (n == {4'd0, LEN_XY}) ? ST_TOUCH : ST_UNKNOWN;
      SC_SLEEP, SC_WAKE:                classify = n3 ? ST_SLEEP : ST_UNKNOWN;
      SC_STRING:                        classify = ST_STRING;
      SC_NUMBER: classify = (n == {4'd0, LEN_NUMBER}) ? ST_NUMBER : ST_UNKNOWN;
      SC_SENDME: classify = (n == {4'd0, LEN_SHORT}) ? ST_SENDME : ST_UNKNOWN;
      SC_TD_END:                        classify = n3 ? ST_TD_END : ST_UNKNOWN;
      SC_TD_READY:                      classify = n3 ? ST_TD_READY : ST_UNKNOWN;
      default:                          classify = ST_UNKNOWN;
    endcase
  endfunction

  // a fresh read acts as if the frame state were cleared first
  assign idx     = fresh_read_i ? 8'd0 : byte_index_q;
  assign p0      = fresh_read_i ? 8'd0 : prev0_q;
  assign p1      = fresh_read_i ? 8'd0 : prev1_q;
  assign exp_cur = (idx == 8'd0) ? min_length(rx_byte_i)
                 : (fresh_read_i ? LEN_DEFAULT : exp_len_q);
  assign code    = (idx == 8'd0) ? rx_byte_i : head_q[0];
  assign is_end  = (idx >= {4'd0, exp_cur}) && (rx_byte_i == END_BYTE) &&
                   (p0 == END_BYTE) && (p1 == END_BYTE);
  assign cnt_inc = {1'b0, idx} + 9'd1;
  assign limit   = event_limit_i ? 9'(EVENT_BUFFER_BYTES) : 9'(CMD_BUFFER_BYTES);
  assign st      = classify(code, idx, head_q[1], head_q[2]);

  always_comb begin
    rec_o = '0;
    byte_index_d = byte_index_q;
    exp_len_d    = exp_len_q;
    prev0_d      = prev0_q;
    prev1_d      = prev1_q;
    if (!enabled_i) begin
      rec_o.status = ST_NOT_INIT;
    end else if (is_end) begin
      rec_o.status  = st;
      rec_o.code    = code;
      rec_o.b1      = head_q[1];
      rec_o.b2      = head_q[2];
      rec_o.b3      = head_q[3];
      rec_o.b4      = head_q[4];
      rec_o.b5      = head_q[5];
      rec_o.str_len = idx - 8'd3;
      byte_index_d  = 8'd0;
      exp_len_d     = LEN_DEFAULT;
      prev0_d       = 8'd0;
      prev1_d       = 8'd0;
    end else if (cnt_inc >= limit) begin
      rec_o.status = ST_BUF_OVFL;
      byte_index_d = 8'd0;
      exp_len_d    = LEN_DEFAULT;
      prev0_d      = 8'd0;
      prev1_d      = 8'd0;
    end else begin
      rec_o.status = ST_INCOMPLETE;
      byte_index_d = cnt_inc[7:0];
      exp_len_d    = exp_cur;
      prev0_d      = p1;
      prev1_d      = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= 8'd0;
      exp_len_q    <= LEN_DEFAULT;
      prev0_q      <= 8'd0;
      prev1_q      <= 8'd0;
    end else if (accept_i) begin
      byte_index_q <= byte_index_d;
      exp_len_q    <= exp_len_d;
      prev0_q      <= prev0_d;
      prev1_q      <= prev1_d;
    end
  end

  // frame head, no reset: entries not yet written in the current frame keep bytes of an earlier frame
  always_ff @(posedge clk_i) begin
    if (accept_i && enabled_i && idx < 8'(HEAD_DEPTH)) begin
      head_q[idx[HEAD_AW-1:0]] <= rx_byte_i;
    end
  end

  a_index_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q < 8'(CMD_BUFFER_BYTES))
    else $error("byte index reached buffer limit");

  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !enabled_i |=> $stable(byte_index_q) && $stable(prev1_q))
    else $error("frame state moved while parser disabled");

endmodule

FILE: sv/dfrp_queue.sv
module dfrp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dfrp_pkg::rec_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dfrp_pkg::rec_t pop_data_o
);
  import dfrp_pkg::*;

  rec_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

FILE: sv/dfrp_back.sv
module dfrp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  dfrp_pkg::rec_t rec_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [4:0]     status_o,
  output logic [7:0]     start_code_o,
  output logic [15:0]    page_or_x_o,
  output logic [15:0]    comp_or_y_o,
  output logic [7:0]     touch_action_o,
  output logic           event_valid_o,
  output logic [7:0]     error_code_o,
  output logic [7:0]     string_length_o
);
  import dfrp_pkg::*;

  logic        valid_q;
  logic [4:0]  status_q, status_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] page_q, page_d;
  logic [15:0] comp_q, comp_d;
  logic [7:0]  action_q, action_d;
  logic        ev_q, ev_d;
  logic [7:0]  err_q, err_d;
  logic [7:0]  slen_q, slen_d;

  assign pop_o = !empty_i && (!valid_q || ready_i);

  // field decode per result kind
  always_comb begin
    status_d = rec_i.status;
    code_d   = rec_i.code;
    page_d   = 16'd0;
    comp_d   = 16'd0;
    action_d = 8'd0;
    ev_d     = 1'b0;
    err_d    = 8'd0;
    slen_d   = 8'd0;
    case (rec_i.status)
      ST_TOUCH: begin
        ev_d = 1'b1;
        if (rec_i.code == SC_TOUCH) begin
          page_d   = {8'd0, rec_i.b1};
          comp_d   = {8'd0, rec_i.b2};
          action_d = rec_i.b3;
        end else begin
          page_d   = {rec_i.b1, rec_i.b2};
          comp_d   = {rec_i.b3, rec_i.b4};
          action_d = rec_i.b5;
        end
      end
      ST_SLEEP: ev_d = 1'b1;
      ST_SENDME: begin
        ev_d   = 1'b1;
        page_d = {8'd0, rec_i.b1};
      end
      ST_WRONG_ID, ST_UNKNOWN: err_d = rec_i.code;
      ST_STRING:               slen_d = rec_i.str_len;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      code_q   <= code_d;
      page_q   <= page_d;
      comp_q   <= comp_d;
      action_q <= action_d;
      ev_q     <= ev_d;
      err_q    <= err_d;
      slen_q   <= slen_d;
    end
  end

  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign start_code_o    = code_q;
  assign page_or_x_o     = page_q;
  assign comp_or_y_o     = comp_q;
  assign touch_action_o  = action_q;
  assign event_valid_o   = ev_q;
  assign error_code_o    = err_q;
  assign string_length_o = slen_q;

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped word not presented");

  a_event_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ev_q |-> (status_q == ST_TOUCH || status_q == ST_SLEEP ||
                         status_q == ST_SENDME))
    else $error("event flag on non-event result");

endmodule

FILE: sv/display_reply_frame_parser_top.sv
// path: a byte's result word is pushed into the queue when the byte is accepted, then
//   popped into the output register, from which it is presented
// throughput: one byte per cycle while the result side keeps up; on a result stall
//   the queue and output register hold up to three words, then s_axis_tready drops
// reset (rst_ni low, async): parser disabled, frame state cleared, queue and
//   output register empty; frame head bytes are not reset
module display_reply_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: 1 enables the parser
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [0] fresh_read, [1] event_limit
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] start_code, [23:8] page_or_x,
                                      // [39:24] comp_or_y, [47:40] touch_action,
                                      // [55:48] error_code, [63:56] string_length
  output logic [5:0]  m_axis_tuser    // [4:0] status, [5] event_valid
);
  import dfrp_pkg::*;

  logic enabled_q;
  logic accept;
  logic q_full, q_empty, q_pop;
  rec_t front_rec, queue_rec;

  logic [4:0]  status;
  logic [7:0]  start_code;
  logic [15:0] page_or_x;
  logic [15:0] comp_or_y;
  logic [7:0]  touch_action;
  logic        event_valid;
  logic [7:0]  error_code;
  logic [7:0]  string_length;

  // enable register, write-only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (cfg_we_i) begin
      enabled_q <= cfg_wdata_i;
    end
  end

  // a byte is taken whenever the queue has room
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front: frame tracking and classification, one byte per cycle while the queue has room
  dfrp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .enabled_i     (enabled_q),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata),
    .fresh_read_i  (s_axis_tuser[0]),
    .event_limit_i (s_axis_tuser[1]),
    .rec_o         (front_rec)
  );

  // short queue decoupling parser from output stalls
  dfrp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_rec),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (queue_rec)
  );

  // back: result field decode into the output register
  dfrp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .rec_i           (queue_rec),
    .pop_o           (q_pop),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .status_o        (status),
    .start_code_o    (start_code),
    .page_or_x_o     (page_or_x),
    .comp_or_y_o     (comp_or_y),
    .touch_action_o  (touch_action),
    .event_valid_o   (event_valid),
    .error_code_o    (error_code),
    .string_length_o (string_length)
  );

  assign m_axis_tdata = {string_length, error_code, touch_action,
                         comp_or_y, page_or_x, start_code};
  assign m_axis_tuser = {event_valid, status};

endmodule
